[rtl/psc_pkg.sv]
// psc_pkg: shared widths, register indexes, command types and controller states
// for the pressure sensor compensation unit; no dependencies
`default_nettype none

package psc_pkg;

  // field widths
  localparam int WORD_W  = 24;
  localparam int COEFF_W = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 22;
  localparam int IDX_W   = 3;

  typedef logic [WORD_W-1:0]         word_t;
  typedef logic [COEFF_W-1:0]        coeff_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [TEMP_W-1:0]  temp_t;
  typedef logic signed [PRES_W-1:0]  pres_t;

  // configuration register indexes
  localparam idx_t REG_SENS_BASE   = 3'd0;
  localparam idx_t REG_OFFSET_BASE = 3'd1;
  localparam idx_t REG_SENS_TEMP   = 3'd2;
  localparam idx_t REG_OFFSET_TEMP = 3'd3;
  localparam idx_t REG_REF_TEMP    = 3'd4;
  localparam idx_t REG_TEMP_SLOPE  = 3'd5;

  // operand pairs for the shared multiplier
  typedef enum logic [2:0] {
    MUL_C6_DT,
    MUL_C4_DT,
    MUL_C3_DT,
    MUL_D1_LO,
    MUL_D1_HI
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     cap_d1;
    logic     cap_dt;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     save_temp;
    logic     save_off;
    logic     save_sens;
    logic     save_lo;
    logic     acc_add;
    logic     load_out;
  } cmd_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_T,
    S_MUL_OFF,
    S_MUL_SENS,
    S_SENS,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/psc_adc_if.sv]
// psc_adc_if: input channel carrying one raw adc word
// depends on psc_pkg
`default_nettype none

interface psc_adc_if;
  logic              valid;
  logic              ready;
  psc_pkg::word_t    adc_word;

  modport source (output valid, output adc_word, input ready);
  modport sink   (input valid, input adc_word, output ready);
endinterface

`default_nettype wire

[rtl/psc_result_if.sv]
// psc_result_if: output channel carrying compensated temperature and pressure
// depends on psc_pkg
`default_nettype none

interface psc_result_if;
  logic              valid;
  logic              ready;
  psc_pkg::temp_t    temperature;
  psc_pkg::pres_t    pressure;

  modport source (output valid, output temperature, output pressure, input ready);
  modport sink   (input valid, input temperature, input pressure, output ready);
endinterface

`default_nettype wire

[rtl/psc_cfg_if.sv]
// psc_cfg_if: configuration write channel, register index and data
// depends on psc_pkg
`default_nettype none

interface psc_cfg_if;
  logic              valid;
  logic              ready;
  psc_pkg::idx_t     index;
  psc_pkg::coeff_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/psc_ctrl.sv]
// psc_ctrl: sequencing state machine, word phase and output valid flag
// depends on psc_pkg
`default_nettype none

module psc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output psc_pkg::cmd_t cmd
);
  import psc_pkg::*;

  state_t state, state_next;
  logic   expect_temperature;
  logic   in_fire;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // state and phase registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      expect_temperature <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        expect_temperature <= !expect_temperature;
      end
    end
  end

  // output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && expect_temperature) begin
          state_next = S_MUL_T;
        end
      end
      S_MUL_T:    state_next = S_MUL_OFF;
      S_MUL_OFF:  state_next = S_MUL_SENS;
      S_MUL_SENS: state_next = S_SENS;
      S_SENS:     state_next = S_MUL_LO;
      S_MUL_LO:   state_next = S_MUL_HI;
      S_MUL_HI:   state_next = S_ACC;
      S_ACC:      state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_C6_DT;
    unique case (state)
      S_IDLE: begin
        cmd.cap_d1 = in_fire && !expect_temperature;
        cmd.cap_dt = in_fire && expect_temperature;
      end
      S_MUL_T: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_C6_DT;
      end
      S_MUL_OFF: begin
        cmd.save_temp = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_C4_DT;
      end
      S_MUL_SENS: begin
        cmd.save_off = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_C3_DT;
      end
      S_SENS: begin
        cmd.save_sens = 1'b1;
      end
      S_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D1_LO;
      end
      S_MUL_HI: begin
        cmd.save_lo = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D1_HI;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
      end
      S_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/psc_dp.sv]
// psc_dp: coefficient registers, held pressure word, shared 25x18 multiplier
// and compensation arithmetic; depends on psc_pkg
`default_nettype none

module psc_dp (
  input  logic            clk,
  input  logic            rst,
  input  psc_pkg::cmd_t   cmd,
  input  psc_pkg::word_t  word,
  input  logic            cfg_we,
  input  psc_pkg::idx_t   cfg_index,
  input  psc_pkg::coeff_t cfg_data,
  output psc_pkg::temp_t  temperature,
  output psc_pkg::pres_t  pressure
);
  import psc_pkg::*;

  coeff_t sens_base_coeff;
  coeff_t offset_base_coeff;
  coeff_t sens_temp_coeff;
  coeff_t offset_temp_coeff;
  coeff_t ref_temp_coeff;
  coeff_t temp_slope_coeff;
  word_t  held_pressure_word;

  logic signed [24:0] dt, dt_next;
  logic signed [24:0] op_a;
  logic signed [17:0] op_b;
  logic signed [42:0] mul_out;
  logic signed [42:0] prod;
  logic signed [19:0] temp_sum;
  temp_t              temp;
  logic signed [35:0] off, off_next;
  logic signed [34:0] sens_sum;
  logic signed [33:0] sens;
  logic signed [59:0] acc;
  logic signed [38:0] pres_diff;

  // coefficient registers, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sens_base_coeff   <= '0;
      offset_base_coeff <= '0;
      sens_temp_coeff   <= '0;
      offset_temp_coeff <= '0;
      ref_temp_coeff    <= '0;
      temp_slope_coeff  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENS_BASE:   sens_base_coeff   <= cfg_data;
        REG_OFFSET_BASE: offset_base_coeff <= cfg_data;
        REG_SENS_TEMP:   sens_temp_coeff   <= cfg_data;
        REG_OFFSET_TEMP: offset_temp_coeff <= cfg_data;
        REG_REF_TEMP:    ref_temp_coeff    <= cfg_data;
        REG_TEMP_SLOPE:  temp_slope_coeff  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // held pressure word
  always_ff @(posedge clk) begin
    if (rst) begin
      held_pressure_word <= '0;
    end else if (cmd.cap_d1) begin
      held_pressure_word <= word;
    end
  end

  // dT = D2 - C5 * 256
  assign dt_next = $signed({1'b0, word}) - $signed({1'b0, ref_temp_coeff, 8'h00});

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_C6_DT: begin
        op_a = dt;
        op_b = $signed({2'b00, temp_slope_coeff});
      end
      MUL_C4_DT: begin
        op_a = dt;
        op_b = $signed({2'b00, offset_temp_coeff});
      end
      MUL_C3_DT: begin
        op_a = dt;
        op_b = $signed({2'b00, sens_temp_coeff});
      end
      MUL_D1_LO: begin
        op_a = $signed({1'b0, held_pressure_word});
        op_b = $signed({1'b0, sens[16:0]});
      end
      MUL_D1_HI: begin
        op_a = $signed({1'b0, held_pressure_word});
        op_b = $signed({sens[33], sens[33:17]});
      end
      default: begin
        op_a = dt;
        op_b = '0;
      end
    endcase
  end

  assign mul_out = op_a * op_b;

  // TEMP = 2000 + (C6*dT) >> 23
  assign temp_sum = $signed(prod[42:23]) + 20'sd2000;
  // OFF = C2 << 16 + (C4*dT) >> 7
  assign off_next = $signed(prod[42:7]) + $signed({4'b0000, offset_base_coeff, 16'h0000});
  // SENS = C1 << 15 + (C3*dT) >> 8
  assign sens_sum = $signed(prod[42:8]) + $signed({4'b0000, sens_base_coeff, 15'h0000});
  // P = ((D1*SENS) >> 21 - OFF) >> 15
  assign pres_diff = $signed(acc[59:21]) - $signed({{3{off[35]}}, off});

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.cap_dt) begin
      dt <= dt_next;
    end
    if (cmd.mul_en) begin
      prod <= mul_out;
    end
    if (cmd.save_temp) begin
      temp <= temp_sum[TEMP_W-1:0];
    end
    if (cmd.save_off) begin
      off <= off_next;
    end
    if (cmd.save_sens) begin
      sens <= sens_sum[33:0];
    end
    // D1*SENS built from a low and a high partial product
    if (cmd.save_lo) begin
      acc <= {{17{prod[42]}}, prod};
    end else if (cmd.acc_add) begin
      acc <= acc + $signed({prod, 17'h00000});
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      temperature <= temp;
      pressure    <= pres_diff[36:15];
    end
  end

endmodule

`default_nettype wire

[rtl/pressure_sensor_compensation_unit.sv]
// pressure_sensor_compensation_unit: top level, joins controller and datapath
// depends on psc_pkg, psc_adc_if, psc_result_if, psc_cfg_if, psc_ctrl, psc_dp
//
// usage
//   adc: raw 24-bit conversion words, alternating pressure then temperature.
//     A pressure word is held and gives no result; a temperature word runs
//     first-order compensation and gives one result word.
//   result: compensated temperature (centidegrees) and pressure, held in an
//     output register until taken.
//   cfg: write channel for the six calibration coefficients, always ready.
//     Write them only while the block is idle.
// timing
//   a pressure word is held and adc stays ready; a temperature word gives its
//   result after five passes through the one shared 25x18 multiplier plus the
//   sens, accumulate and final subtract steps.
//   adc is ready again the cycle after the result is loaded.
// reset
//   coefficients clear to zero, a pressure word is expected first and the
//   held pressure word is zero. If result stalls, the block waits in its
//   last step with the next result until the output register frees up.
`default_nettype none

module pressure_sensor_compensation_unit (
  input logic          clk,
  input logic          rst,
  psc_adc_if.sink      adc,
  psc_result_if.source result,
  psc_cfg_if.sink      cfg
);
  import psc_pkg::*;

  cmd_t cmd;

  assign cfg.ready = 1'b1;

  // sequencing
  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (adc.valid),
    .in_ready  (adc.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  // arithmetic and storage
  psc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .word        (adc.adc_word),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .temperature (result.temperature),
    .pressure    (result.pressure)
  );

endmodule

`default_nettype wire

[tb/psc_compensation_checker.sv]
// psc_compensation_checker: predicts compensated temperature and pressure from the
// adc and cfg words it sees and compares them with the result words in order
// depends on psc_pkg, psc_adc_if, psc_result_if, psc_cfg_if
`default_nettype none

module psc_compensation_checker (
  input  logic   clk,
  input  logic   rst,
  psc_adc_if     adc,
  psc_result_if  result,
  psc_cfg_if     cfg,
  output int     fail_count,
  output int     pending
);
  import psc_pkg::*;

  // first-order compensation constants
  localparam longint TEMP_REF    = 2000;
  localparam int     TEMP_SHIFT  = 23;
  localparam int     OFF_SHIFT   = 7;
  localparam int     SENS_SHIFT  = 8;
  localparam int     PROD_SHIFT  = 21;
  localparam int     PRES_SHIFT  = 15;
  localparam int     CAL_REGS    = REG_TEMP_SLOPE + 1;

  typedef struct {
    temp_t temperature;
    pres_t pressure;
  } reading_t;

  coeff_t   cal [CAL_REGS];
  logic     expect_temp;
  word_t    held_pressure;
  reading_t expected_readings [$];
  int       errors;

  // compensated reading for one pressure/temperature pair under current calibration
  function automatic reading_t compensate(input word_t d1_word, input word_t d2_word);
    longint   c1, c2, c3, c4, c5, c6, d1, d2;
    longint   dt, t, off, sens, p;
    reading_t r;
    c1 = cal[REG_SENS_BASE];
    c2 = cal[REG_OFFSET_BASE];
    c3 = cal[REG_SENS_TEMP];
    c4 = cal[REG_OFFSET_TEMP];
    c5 = cal[REG_REF_TEMP];
    c6 = cal[REG_TEMP_SLOPE];
    d1 = d1_word;
    d2 = d2_word;
    dt   = d2 - c5 * 256;
    t    = TEMP_REF + ((c6 * dt) >>> TEMP_SHIFT);
    off  = c2 * 65536 + ((c4 * dt) >>> OFF_SHIFT);
    sens = c1 * 32768 + ((c3 * dt) >>> SENS_SHIFT);
    p    = (((d1 * sens) >>> PROD_SHIFT) - off) >>> PRES_SHIFT;
    r.temperature = t[TEMP_W-1:0];
    r.pressure    = p[PRES_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      foreach (cal[i]) cal[i] = '0;
      expect_temp   = 1'b0;
      held_pressure = '0;
      expected_readings.delete();
      errors = 0;
    end else begin
      // calibration writes, indexes past the last register are dropped
      if (cfg.valid && cfg.ready && cfg.index <= REG_TEMP_SLOPE) begin
        cal[cfg.index] = cfg.data;
      end
      // pressure word is held, temperature word yields one reading
      if (adc.valid && adc.ready) begin
        if (expect_temp) begin
          expected_readings.push_back(compensate(held_pressure, adc.adc_word));
        end else begin
          held_pressure = adc.adc_word;
        end
        expect_temp = !expect_temp;
      end
      // compare each result word with the oldest prediction
      if (result.valid && result.ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result word, temperature %0d pressure %0d",
                   $time, result.temperature, result.pressure);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (result.temperature !== want.temperature) begin
            $display("%0t: temperature mismatch, expected %0d, got %0d",
                     $time, want.temperature, result.temperature);
            errors++;
          end
          if (result.pressure !== want.pressure) begin
            $display("%0t: pressure mismatch, expected %0d, got %0d",
                     $time, want.pressure, result.pressure);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_readings.size();
  end

endmodule

`default_nettype wire

[tb/pressure_sensor_compensation_unit_test.sv]
// pressure_sensor_compensation_unit_test: drives adc and cfg words with random
// idling, stalls the result side and reports the verdict
// depends on psc_pkg, the three channel interfaces, the unit and psc_compensation_checker
`default_nettype none

module pressure_sensor_compensation_unit_test;
  import psc_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PHASES          = 9;
  localparam int PAIRS_PER_PHASE = 75;

  logic   clk;
  logic   rst;
  int     send_idle = 25;
  int     recv_idle = 65;
  int     fail_count;
  int     pending;
  int     cycles;
  coeff_t cal_set [REG_TEMP_SLOPE + 1];

  psc_adc_if    adc_ch ();
  psc_result_if res_ch ();
  psc_cfg_if    cfg_ch ();

  pressure_sensor_compensation_unit dut (
    .clk    (clk),
    .rst    (rst),
    .adc    (adc_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  psc_compensation_checker comp_check (
    .clk        (clk),
    .rst        (rst),
    .adc        (adc_ch),
    .result     (res_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side stalls at random
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // one adc word, optional gap first; valid stays high on return
  task automatic send_word(input word_t w);
    while ($urandom_range(0, 99) < send_idle) begin
      adc_ch.valid <= 1'b0;
      @(negedge clk);
    end
    adc_ch.valid    <= 1'b1;
    adc_ch.adc_word <= w;
    do @(posedge clk); while (!adc_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_pair(input word_t pres_word, input word_t temp_word);
    send_word(pres_word);
    send_word(temp_word);
  endtask

  // one cfg word; valid stays high until end_cfg
  task automatic write_reg(input idx_t idx, input coeff_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic end_cfg();
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // all six coefficients plus one write to an unused index
  task automatic load_cal();
    for (int i = REG_SENS_BASE; i <= REG_TEMP_SLOPE; i++) begin
      write_reg(idx_t'(i), cal_set[i]);
    end
    write_reg(idx_t'(REG_TEMP_SLOPE + 1 + $urandom_range(0, 1)), coeff_t'($urandom()));
    end_cfg();
  endtask

  // drain outstanding readings, then let a pending pressure word finish
  task automatic settle();
    adc_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // extremes, words near the reference temperature, or anything
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return {cal_set[REG_REF_TEMP], 8'h00} + word_t'($urandom_range(0, 8191))
                      - word_t'(4096);
      default: return word_t'($urandom());
    endcase
  endfunction

  initial begin
    rst             = 1'b1;
    adc_ch.valid    = 1'b0;
    adc_ch.adc_word = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    foreach (cal_set[i]) cal_set[i] = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // zero calibration out of reset, first pressure word zero
    send_pair('0, '0);
    send_pair('1, '1);

    // typical datasheet calibration
    settle();
    cal_set = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
    load_cal();
    send_pair('1, '1);
    send_pair('1, '0);
    send_pair('0, '1);
    send_pair(24'd9085466, 24'd8569150);
    // dt of zero and of minus one
    send_pair(24'd9085466, {cal_set[REG_REF_TEMP], 8'h00});
    send_pair(24'd9085466, {cal_set[REG_REF_TEMP], 8'h00} - 1'b1);

    // slope changed between pressure and temperature word
    send_word(24'd8000000);
    settle();
    cal_set[REG_TEMP_SLOPE] = 16'd1234;
    write_reg(REG_TEMP_SLOPE, cal_set[REG_TEMP_SLOPE]);
    end_cfg();
    send_word(24'd8500000);

    // all coefficients at full scale
    settle();
    foreach (cal_set[i]) cal_set[i] = '1;
    load_cal();
    send_pair('1, '0);
    send_pair('0, '1);
    send_pair('1, '1);

    // random phases, each under its own calibration
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      send_idle = (ph < 3) ? 25 : (ph < 6) ? 65 : 0;
      recv_idle = (ph < 3) ? 65 : (ph < 6) ? 25 : 0;
      foreach (cal_set[i]) begin
        case ($urandom_range(0, 5))
          0: cal_set[i] = '0;
          1: cal_set[i] = '1;
          default: cal_set[i] = coeff_t'($urandom());
        endcase
        if (ph == 1) cal_set[i] = '1;
        if (ph == 4) cal_set[i] = '0;
      end
      load_cal();
      repeat (PAIRS_PER_PHASE) send_pair(pick_word(), pick_word());
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[pressure_sensor_compensation_unit.f]
rtl/psc_pkg.sv
rtl/psc_adc_if.sv
rtl/psc_result_if.sv
rtl/psc_cfg_if.sv
rtl/psc_ctrl.sv
rtl/psc_dp.sv
rtl/pressure_sensor_compensation_unit.sv
tb/psc_compensation_checker.sv
tb/pressure_sensor_compensation_unit_test.sv
